// ----- sv/sps_pkg.sv -----
`default_nettype none
package sps_pkg;

    localparam int MAX_GOLOMB_ZEROS   = 31;
    localparam int SCALING_FLAG_COUNT = 8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_SPS   = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_LONG      = 3'd3;
    localparam logic [2:0] ST_OVER      = 3'd4;
    localparam logic [2:0] ST_ZERO_TICK = 3'd5;
    localparam logic [2:0] ST_SCALING   = 3'd6;

    typedef enum logic [5:0] {
        S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_RESID,
        S_BDL, S_BDC, S_BYPASS, S_SMP, S_SLF, S_LOG2FN, S_POCT, S_LOG2POC,
        S_DPOAZ, S_OFFNR, S_OFFTB, S_NREFCYC, S_OFFREF, S_NUMREF, S_GAPS,
        S_WIDTH, S_HEIGHT, S_FMO, S_MBAFF, S_D8, S_CROP, S_CROPOFF, S_VUI,
        S_ARP, S_ARIDC, S_SAR, S_OVP, S_OVA, S_VST, S_VFMT, S_COLOUR,
        S_CLOC, S_CLOCVAL, S_TIMING, S_TICK, S_TSCALE, S_FIXED, S_DONE
    } syn_t;

    function automatic logic [5:0] step_width(input syn_t s);
        case (s)
            S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_ARIDC: step_width = 6'd8;
            S_RESID, S_BYPASS, S_SMP, S_SLF, S_DPOAZ, S_GAPS, S_FMO, S_MBAFF,
            S_D8, S_CROP, S_VUI, S_ARP, S_OVP, S_OVA, S_VST, S_CLOC,
            S_TIMING, S_FIXED: step_width = 6'd1;
            S_VFMT: step_width = 6'd5;
            S_COLOUR: step_width = 6'd24;
            S_SAR, S_TICK, S_TSCALE: step_width = 6'd32;
            default: step_width = 6'd0;
        endcase
    endfunction

    typedef struct packed {
        logic load_byte;
        logic shift_bit;
        logic div_start;
        logic emit;
    } sps_cmd_t;

    typedef struct packed {
        logic bits_empty;
        logic div_busy;
    } sps_sts_t;

endpackage
`default_nettype wire

// ----- sv/sps_div.sv -----
`default_nettype none
module sps_div
    import sps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [31:0]      quotient
);

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [33:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        trial = {1'b0, r_reg, q_reg[31]} - {2'b00, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (!trial[33])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign quotient = q_reg;

endmodule
`default_nettype wire

// ----- sv/sps_datapath.sv -----
`default_nettype none
module sps_datapath
    import sps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sps_cmd_t    cmd,
    output sps_sts_t         sts,
    input  wire logic [7:0]  nal_byte,
    output logic [15:0]      width_pixels,
    output logic [15:0]      height_pixels,
    output logic [31:0]      frames_per_second,
    output logic [2:0]       status
);

    logic [1:0]  zrun_reg, zrun_next;
    logic [7:0]  sh_reg, sh_next;
    logic [3:0]  nb_reg, nb_next;
    syn_t        step_reg, step_next;
    logic [5:0]  gz_reg, gz_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  bl_reg, bl_next;
    logic [31:0] rep_reg, rep_next;
    logic        hp_reg, hp_next;
    logic [31:0] wm_reg, wm_next, hm_reg, hm_next;
    logic [31:0] tick_reg, tick_next, ts_reg, ts_next;
    logic        fix_reg, fix_next, tim_reg, tim_next;
    logic [2:0]  pst_reg, pst_next;
    logic        done_reg, done_next;
    logic [15:0] wpix_reg, wpix_next, hpix_reg, hpix_next;
    logic [31:0] fps_reg, fps_next;
    logic [2:0]  rst_reg, rst_next;

    logic        b;
    logic [31:0] acc_sh, v;
    logic        fin;
    syn_t        nxt;
    logic        go;
    logic [31:0] rep_dec;
    logic        div_busy;
    logic [31:0] quo;
    logic        over_w, over_h;
    logic [2:0]  st_pre;
    logic [15:0] w_res, h_res;
    logic [31:0] fps_res;
    logic [2:0]  st_res;

    sps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (ts_reg),
        .divisor  (tick_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_comb
    begin
        zrun_next = zrun_reg; sh_next = sh_reg; nb_next = nb_reg;
        step_next = step_reg; gz_next = gz_reg; acc_next = acc_reg;
        bl_next = bl_reg; rep_next = rep_reg; hp_next = hp_reg;
        wm_next = wm_reg; hm_next = hm_reg; tick_next = tick_reg;
        ts_next = ts_reg; fix_next = fix_reg; tim_next = tim_reg;
        pst_next = pst_reg; done_next = done_reg;
        b = sh_reg[7];
        acc_sh = {acc_reg[30:0], b};
        fin = 1'b0;
        v = '0;
        nxt = S_DONE;
        go = 1'b0;
        rep_dec = rep_reg - 32'd1;

        if (cmd.load_byte)
        begin
            if (zrun_reg == 2'd2 && nal_byte == 8'h03)
            begin
                zrun_next = 2'd0;
                nb_next = 4'd0;
            end
            else
            begin
                zrun_next = (nal_byte != 8'd0) ? 2'd0 :
                            (zrun_reg == 2'd2 ? 2'd2 : zrun_reg + 2'd1);
                sh_next = nal_byte;
                nb_next = 4'd8;
            end
        end
        else if (cmd.shift_bit && nb_reg != 4'd0)
        begin
            sh_next = {sh_reg[6:0], 1'b0};
            nb_next = nb_reg - 4'd1;
            if (!done_reg)
            begin
                if (step_reg == S_DONE)
                    done_next = 1'b1;
                else if (step_width(step_reg) != 6'd0 || bl_reg != 6'd0)
                begin
                    acc_next = acc_sh;
                    bl_next = bl_reg - 6'd1;
                    if (bl_reg == 6'd1)
                    begin
                        fin = 1'b1;
                        if (step_width(step_reg) != 6'd0)
                            v = acc_sh;
                        else
                            v = ((32'd1 << gz_reg[4:0]) - 32'd1) + acc_sh;
                    end
                end
                else if (!b)
                begin
                    gz_next = gz_reg + 6'd1;
                    if (gz_reg == 6'(MAX_GOLOMB_ZEROS))
                    begin
                        pst_next = ST_LONG;
                        done_next = 1'b1;
                    end
                end
                else if (gz_reg == 6'd0)
                begin
                    fin = 1'b1;
                    v = '0;
                end
                else
                begin
                    bl_next = gz_reg;
                    acc_next = '0;
                end
            end
        end

        if (fin)
        begin
            go = 1'b1;
            case (step_reg)
                S_HDR:
                    if (v[4:0] != 5'd7)
                    begin
                        go = 1'b0;
                        pst_next = ST_NOT_SPS;
                        done_next = 1'b1;
                    end
                    else nxt = S_PROFILE;
                S_PROFILE:
                begin
                    hp_next = (v == 32'd100 || v == 32'd110 || v == 32'd122 ||
                               v == 32'd144);
                    nxt = S_CONSTR;
                end
                S_CONSTR:  nxt = S_LEVEL;
                S_LEVEL:   nxt = S_SPSID;
                S_SPSID:   nxt = hp_reg ? S_CHROMA : S_LOG2FN;
                S_CHROMA:  nxt = (v == 32'd3) ? S_RESID : S_BDL;
                S_RESID:   nxt = S_BDL;
                S_BDL:     nxt = S_BDC;
                S_BDC:     nxt = S_BYPASS;
                S_BYPASS:  nxt = S_SMP;
                S_SMP:
                begin
                    rep_next = '0;
                    nxt = (v != 0) ? S_SLF : S_LOG2FN;
                end
                S_SLF:
                    if (v != 0)
                    begin
                        go = 1'b0;
                        pst_next = ST_SCALING;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rep_next = rep_reg + 32'd1;
                        nxt = (rep_reg + 32'd1 >= 32'(SCALING_FLAG_COUNT)) ?
                              S_LOG2FN : S_SLF;
                    end
                S_LOG2FN:  nxt = S_POCT;
                S_POCT:    nxt = (v == 0) ? S_LOG2POC :
                                 ((v == 32'd1) ? S_DPOAZ : S_NUMREF);
                S_LOG2POC: nxt = S_NUMREF;
                S_DPOAZ:   nxt = S_OFFNR;
                S_OFFNR:   nxt = S_OFFTB;
                S_OFFTB:   nxt = S_NREFCYC;
                S_NREFCYC:
                begin
                    rep_next = v;
                    nxt = (v == 0) ? S_NUMREF : S_OFFREF;
                end
                S_OFFREF, S_CROPOFF, S_CLOCVAL:
                begin
                    rep_next = rep_dec;
                    if (rep_dec != 0)
                        nxt = step_reg;
                    else if (step_reg == S_OFFREF)
                        nxt = S_NUMREF;
                    else if (step_reg == S_CROPOFF)
                        nxt = S_VUI;
                    else
                        nxt = S_TIMING;
                end
                S_NUMREF:  nxt = S_GAPS;
                S_GAPS:    nxt = S_WIDTH;
                S_WIDTH:
                begin
                    wm_next = v;
                    nxt = S_HEIGHT;
                end
                S_HEIGHT:
                begin
                    hm_next = v;
                    nxt = S_FMO;
                end
                S_FMO:     nxt = (v != 0) ? S_D8 : S_MBAFF;
                S_MBAFF:   nxt = S_D8;
                S_D8:      nxt = S_CROP;
                S_CROP:
                begin
                    rep_next = 32'd4;
                    nxt = (v != 0) ? S_CROPOFF : S_VUI;
                end
                S_VUI:     nxt = (v != 0) ? S_ARP : S_DONE;
                S_ARP:     nxt = (v != 0) ? S_ARIDC : S_OVP;
                S_ARIDC:   nxt = (v == 32'd255) ? S_SAR : S_OVP;
                S_SAR:     nxt = S_OVP;
                S_OVP:     nxt = (v != 0) ? S_OVA : S_VST;
                S_OVA:     nxt = S_VST;
                S_VST:     nxt = (v != 0) ? S_VFMT : S_CLOC;
                S_VFMT:    nxt = v[0] ? S_COLOUR : S_CLOC;
                S_COLOUR:  nxt = S_CLOC;
                S_CLOC:
                begin
                    rep_next = 32'd2;
                    nxt = (v != 0) ? S_CLOCVAL : S_TIMING;
                end
                S_TIMING:
                begin
                    tim_next = (v != 0);
                    nxt = (v != 0) ? S_TICK : S_DONE;
                end
                S_TICK:
                begin
                    tick_next = v;
                    nxt = S_TSCALE;
                end
                S_TSCALE:
                begin
                    ts_next = v;
                    nxt = S_FIXED;
                end
                S_FIXED:
                begin
                    fix_next = v[0];
                    nxt = S_DONE;
                end
                default:   nxt = S_DONE;
            endcase
            if (go)
            begin
                step_next = nxt;
                bl_next = step_width(nxt);
                acc_next = '0;
                gz_next = '0;
                if (nxt == S_DONE)
                    done_next = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            zrun_next = '0; hp_next = 1'b0; rep_next = '0; wm_next = '0;
            hm_next = '0; tick_next = '0; ts_next = '0; fix_next = 1'b0;
            tim_next = 1'b0; pst_next = ST_OK; done_next = 1'b0;
            step_next = S_HDR; bl_next = step_width(S_HDR);
            acc_next = '0; gz_next = '0; nb_next = '0;
        end
    end

    always_comb
    begin
        wpix_next = wpix_reg;
        hpix_next = hpix_reg;
        fps_next = fps_reg;
        rst_next = rst_reg;
        if (cmd.emit)
        begin
            wpix_next = w_res;
            hpix_next = h_res;
            fps_next = fps_res;
            rst_next = st_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zrun_reg <= '0; nb_reg <= '0; step_reg <= S_HDR; gz_reg <= '0;
            acc_reg <= '0; bl_reg <= step_width(S_HDR); rep_reg <= '0;
            hp_reg <= 1'b0; wm_reg <= '0; hm_reg <= '0; tick_reg <= '0;
            ts_reg <= '0; fix_reg <= 1'b0; tim_reg <= 1'b0; pst_reg <= ST_OK;
            done_reg <= 1'b0;
            wpix_reg <= '0; hpix_reg <= '0; fps_reg <= '0; rst_reg <= ST_OK;
        end
        else
        begin
            zrun_reg <= zrun_next; nb_reg <= nb_next; step_reg <= step_next;
            gz_reg <= gz_next; acc_reg <= acc_next; bl_reg <= bl_next;
            rep_reg <= rep_next; hp_reg <= hp_next; wm_reg <= wm_next;
            hm_reg <= hm_next; tick_reg <= tick_next; ts_reg <= ts_next;
            fix_reg <= fix_next; tim_reg <= tim_next; pst_reg <= pst_next;
            done_reg <= done_next;
            wpix_reg <= wpix_next; hpix_reg <= hpix_next; fps_reg <= fps_next;
            rst_reg <= rst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign over_w = (wm_reg >= 32'd4095);
    assign over_h = (hm_reg >= 32'd4095);

    always_comb
    begin
        st_pre = done_reg ? pst_reg : ST_TRUNC;
        st_res = st_pre;
        w_res = '0;
        h_res = '0;
        fps_res = '0;
        if (st_pre == ST_OK)
        begin
            w_res = over_w ? 16'hFFFF : {wm_reg[11:0] + 12'd1, 4'd0};
            h_res = over_h ? 16'hFFFF : {hm_reg[11:0] + 12'd1, 4'd0};
            if (tim_reg)
            begin
                if (tick_reg == 32'd0)
                    st_res = ST_ZERO_TICK;
                else
                    fps_res = fix_reg ? {1'b0, quo[31:1]} : quo;
            end
            if (over_w || over_h)
                st_res = ST_OVER;
        end
    end

    assign width_pixels = wpix_reg;
    assign height_pixels = hpix_reg;
    assign frames_per_second = fps_reg;
    assign status = rst_reg;

    assign sts.bits_empty = (nb_reg == 4'd0);
    assign sts.div_busy = div_busy;

endmodule
`default_nettype wire

// ----- sv/sps_ctrl.sv -----
`default_nettype none
module sps_ctrl
    import sps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     in_last,
    output logic          out_valid,
    input  wire logic     out_ready,
    output sps_cmd_t      cmd,
    input  wire sps_sts_t sts
);

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_SHIFT = 4'b0010,
        C_DIV   = 4'b0100,
        C_WAIT  = 4'b1000
    } ctl_t;

    ctl_t state_reg, state_next;
    logic last_reg, last_next;
    logic ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next = state_reg;
        last_next = last_reg;
        cmd = '0;
        in_ready = (state_reg == C_IDLE);
        out_valid = ovalid_reg;
        ovalid_next = ovalid_reg;
        if (out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            C_IDLE:
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    last_next = in_last;
                    state_next = C_SHIFT;
                end
            C_SHIFT:
                if (sts.bits_empty)
                    state_next = last_reg ? C_DIV : C_IDLE;
                else
                    cmd.shift_bit = 1'b1;
            C_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = C_WAIT;
            end
            C_WAIT:
                if (!sts.div_busy && (!ovalid_reg || out_ready))
                begin
                    cmd.emit = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = C_IDLE;
                end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            last_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/h264_sps_header_parser.sv -----
// A byte is taken in C_IDLE and then parsed one bit per cycle in C_SHIFT.
// No new byte is taken until the syntax machine has shifted out every bit of the last one.
// On the last byte, a radix-2 divider forms the frame rate: C_DIV starts it, and C_WAIT
// registers the result once it ends; a last byte that is a dropped 0x03 is not shifted.
// A result held in the output register stalls the next unit only in C_WAIT, before its emit.
// Reset: rst_n is asynchronous and active low and returns the parser to the NAL header.
`default_nettype none
module h264_sps_header_parser
    import sps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // nal_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // width_pixels, height_pixels,
                                             // frames_per_second, status, pad
    output logic             m_axis_tuser    // is_sps
);

    sps_cmd_t    cmd;
    sps_sts_t    sts;
    logic [15:0] w, h;
    logic [31:0] fps;
    logic [2:0]  st;

    sps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sps_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .nal_byte          (s_axis_tdata),
        .width_pixels      (w),
        .height_pixels     (h),
        .frames_per_second (fps),
        .status            (st)
    );

    assign m_axis_tdata = {5'd0, st, fps, h, w};
    assign m_axis_tuser = (st != ST_NOT_SPS);

endmodule
`default_nettype wire

// ----- sv/sps_checker.sv -----
`default_nettype none
module sps_checker
    import sps_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a byte is still being parsed");

    a_notsps: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
        else $error("non-SPS result carries values");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[66:64] != 3'd7)
        else $error("invalid status code");

endmodule

bind h264_sps_header_parser sps_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- tb/tb_h264_sps_header_parser.sv -----
`default_nettype none
module tb_h264_sps_header_parser;
    import sps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        bit        sps;
        bit [15:0] width;
        bit [15:0] height;
        bit [31:0] fps;
        bit [2:0]  status;
    } sps_summary_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;

    sps_summary_t summary_q[$];
    bit           rbsp_bits[$];
    logic [7:0]   nal_bytes[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           error_count;
    int           quiet_cycles;

    // Parser state kept by the testbench.
    int unsigned pz_run;
    syn_t        pz_step;
    int unsigned pz_zeros;
    bit [31:0]   pz_acc;
    int unsigned pz_left;
    bit [31:0]   pz_repeat;
    bit          pz_high;
    bit [31:0]   pz_width1;
    bit [31:0]   pz_height1;
    bit [31:0]   pz_tick;
    bit [31:0]   pz_scale;
    bit          pz_fixed;
    bit          pz_timing;
    bit [2:0]    pz_status;
    bit          pz_done;

    h264_sps_header_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned field_bits(syn_t s);
        case (s)
            S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_ARIDC: return 8;
            S_RESID, S_BYPASS, S_SMP, S_SLF, S_DPOAZ, S_GAPS, S_FMO, S_MBAFF,
            S_D8, S_CROP, S_VUI, S_ARP, S_OVP, S_OVA, S_VST, S_CLOC,
            S_TIMING, S_FIXED: return 1;
            S_VFMT: return 5;
            S_COLOUR: return 24;
            S_SAR, S_TICK, S_TSCALE: return 32;
            default: return 0;
        endcase
    endfunction

    task automatic enter_step(syn_t s);
        pz_step  = s;
        pz_left  = field_bits(s);
        pz_acc   = '0;
        pz_zeros = 0;
        if (s == S_DONE)
        begin
            pz_done = 1'b1;
        end
    endtask

    task automatic abort_parse(bit [2:0] code);
        pz_status = code;
        pz_done   = 1'b1;
    endtask

    task automatic clear_parser();
        pz_run = 0;
        pz_repeat = '0;
        pz_high = 1'b0;
        pz_width1 = '0;
        pz_height1 = '0;
        pz_tick = '0;
        pz_scale = '0;
        pz_fixed = 1'b0;
        pz_timing = 1'b0;
        pz_status = ST_OK;
        pz_done = 1'b0;
        enter_step(S_HDR);
    endtask

    task automatic close_field(bit [31:0] v);
        case (pz_step)
            S_HDR:
                if (v[4:0] != 5'd7) abort_parse(ST_NOT_SPS);
                else enter_step(S_PROFILE);
            S_PROFILE:
            begin
                pz_high = (v == 100 || v == 110 || v == 122 || v == 144);
                enter_step(S_CONSTR);
            end
            S_CONSTR: enter_step(S_LEVEL);
            S_LEVEL: enter_step(S_SPSID);
            S_SPSID: enter_step(pz_high ? S_CHROMA : S_LOG2FN);
            S_CHROMA: enter_step(v == 3 ? S_RESID : S_BDL);
            S_RESID: enter_step(S_BDL);
            S_BDL: enter_step(S_BDC);
            S_BDC: enter_step(S_BYPASS);
            S_BYPASS: enter_step(S_SMP);
            S_SMP:
            begin
                pz_repeat = '0;
                enter_step(v != 0 ? S_SLF : S_LOG2FN);
            end
            S_SLF:
                if (v != 0)
                begin
                    abort_parse(ST_SCALING);
                end
                else
                begin
                    pz_repeat++;
                    enter_step(pz_repeat >= SCALING_FLAG_COUNT ? S_LOG2FN : S_SLF);
                end
            S_LOG2FN: enter_step(S_POCT);
            S_POCT: enter_step(v == 0 ? S_LOG2POC : (v == 1 ? S_DPOAZ : S_NUMREF));
            S_LOG2POC: enter_step(S_NUMREF);
            S_DPOAZ: enter_step(S_OFFNR);
            S_OFFNR: enter_step(S_OFFTB);
            S_OFFTB: enter_step(S_NREFCYC);
            S_NREFCYC:
            begin
                pz_repeat = v;
                enter_step(v == 0 ? S_NUMREF : S_OFFREF);
            end
            S_OFFREF, S_CROPOFF, S_CLOCVAL:
            begin
                pz_repeat--;
                if (pz_repeat != 0) enter_step(pz_step);
                else if (pz_step == S_OFFREF) enter_step(S_NUMREF);
                else if (pz_step == S_CROPOFF) enter_step(S_VUI);
                else enter_step(S_TIMING);
            end
            S_NUMREF: enter_step(S_GAPS);
            S_GAPS: enter_step(S_WIDTH);
            S_WIDTH:
            begin
                pz_width1 = v;
                enter_step(S_HEIGHT);
            end
            S_HEIGHT:
            begin
                pz_height1 = v;
                enter_step(S_FMO);
            end
            S_FMO: enter_step(v != 0 ? S_D8 : S_MBAFF);
            S_MBAFF: enter_step(S_D8);
            S_D8: enter_step(S_CROP);
            S_CROP:
            begin
                pz_repeat = 4;
                enter_step(v != 0 ? S_CROPOFF : S_VUI);
            end
            S_VUI: enter_step(v != 0 ? S_ARP : S_DONE);
            S_ARP: enter_step(v != 0 ? S_ARIDC : S_OVP);
            S_ARIDC: enter_step(v == 255 ? S_SAR : S_OVP);
            S_SAR: enter_step(S_OVP);
            S_OVP: enter_step(v != 0 ? S_OVA : S_VST);
            S_OVA: enter_step(S_VST);
            S_VST: enter_step(v != 0 ? S_VFMT : S_CLOC);
            S_VFMT: enter_step(v[0] ? S_COLOUR : S_CLOC);
            S_COLOUR: enter_step(S_CLOC);
            S_CLOC:
            begin
                pz_repeat = 2;
                enter_step(v != 0 ? S_CLOCVAL : S_TIMING);
            end
            S_TIMING:
            begin
                pz_timing = (v != 0);
                enter_step(v != 0 ? S_TICK : S_DONE);
            end
            S_TICK:
            begin
                pz_tick = v;
                enter_step(S_TSCALE);
            end
            S_TSCALE:
            begin
                pz_scale = v;
                enter_step(S_FIXED);
            end
            S_FIXED:
            begin
                pz_fixed = v[0];
                enter_step(S_DONE);
            end
            default: enter_step(S_DONE);
        endcase
    endtask

    task automatic absorb_bit(bit b);
        bit [63:0] code;
        if (pz_done)
        begin
            return;
        end
        if (pz_step == S_DONE)
        begin
            pz_done = 1'b1;
            return;
        end
        if (field_bits(pz_step) != 0 || pz_left != 0)
        begin
            pz_acc = {pz_acc[30:0], b};
            pz_left--;
            if (pz_left == 0)
            begin
                if (field_bits(pz_step) != 0)
                begin
                    close_field(pz_acc);
                end
                else
                begin
                    code = ((64'd1 << pz_zeros) - 64'd1) + 64'(pz_acc);
                    close_field(code[31:0]);
                end
            end
            return;
        end
        if (!b)
        begin
            pz_zeros++;
            if (pz_zeros > MAX_GOLOMB_ZEROS) abort_parse(ST_LONG);
            return;
        end
        if (pz_zeros == 0)
        begin
            close_field('0);
            return;
        end
        pz_left = pz_zeros;
        pz_acc  = '0;
    endtask

    task automatic predict_byte(logic [7:0] b, logic last);
        sps_summary_t r;
        bit [63:0]    sz;
        bit           over;
        if (pz_run >= 2 && b == 8'h03)
        begin
            pz_run = 0;
        end
        else
        begin
            pz_run = (b == 8'h00) ? ((pz_run >= 2) ? 2 : pz_run + 1) : 0;
            for (int i = 7; i >= 0; i--) absorb_bit(b[i]);
        end
        if (!last)
        begin
            return;
        end
        r = '{default: '0};
        over = 1'b0;
        r.status = pz_done ? pz_status : ST_TRUNC;
        if (r.status == ST_OK)
        begin
            sz = (64'(pz_width1) + 64'd1) * 64'd16;
            if (sz > 64'd65535)
            begin
                over = 1'b1;
                sz = 64'd65535;
            end
            r.width = sz[15:0];
            sz = (64'(pz_height1) + 64'd1) * 64'd16;
            if (sz > 64'd65535)
            begin
                over = 1'b1;
                sz = 64'd65535;
            end
            r.height = sz[15:0];
            if (pz_timing)
            begin
                if (pz_tick == 0)
                begin
                    r.status = ST_ZERO_TICK;
                end
                else
                begin
                    r.fps = pz_scale / pz_tick;
                    if (pz_fixed) r.fps = r.fps >> 1;
                end
            end
            if (over) r.status = ST_OVER;
        end
        r.sps = (r.status != ST_NOT_SPS);
        summary_q.insert(summary_q.size(), r);
        clear_parser();
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        sps_summary_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("h264_sps_header_parser regression: fail");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (summary_q.size() == 0)
                begin
                    report_mismatch("unexpected transfer", m_axis_tdata[63:0], 0);
                end
                else
                begin
                    want = summary_q.pop_front();
                    if (m_axis_tuser !== want.sps)
                        report_mismatch("is_sps", m_axis_tuser, want.sps);
                    if (m_axis_tdata[15:0] !== want.width)
                        report_mismatch("width", m_axis_tdata[15:0], want.width);
                    if (m_axis_tdata[31:16] !== want.height)
                        report_mismatch("height", m_axis_tdata[31:16], want.height);
                    if (m_axis_tdata[63:32] !== want.fps)
                        report_mismatch("fps", m_axis_tdata[63:32], want.fps);
                    if (m_axis_tdata[66:64] !== want.status)
                        report_mismatch("status", m_axis_tdata[66:64], want.status);
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_byte(b, last);
    endtask

    task automatic send_nal();
        for (int i = 0; i < nal_bytes.size(); i++)
            send_byte(nal_bytes[i], i == nal_bytes.size() - 1);
    endtask

    task automatic put_bits(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) rbsp_bits.insert(rbsp_bits.size(), v[i]);
    endtask

    task automatic put_ue(logic [32:0] v);
        logic [32:0] x;
        int          msb;
        x = v + 33'd1;
        msb = 0;
        for (int i = 0; i < 33; i++) if (x[i]) msb = i;
        put_bits('0, msb);
        put_bits(64'(x), msb + 1);
    endtask

    function automatic logic [32:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 7);
        if (r < 92) return $urandom_range(0, 255);
        if (r < 96) return 33'h0_FFFF_FFFE;
        return {1'b0, $urandom} % 33'h0_FFFF_FFFF;
    endfunction

    function automatic logic [32:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 127);
        if (r < 86) return 4094;
        if (r < 92) return 4095;
        return pick_code();
    endfunction

    // Ends the payload with a stop bit and zero padding, then, if escape is set, escapes start-code look-alikes.
    task automatic pack_nal(bit escape);
        logic [7:0] b;
        int         zeros;
        rbsp_bits.insert(rbsp_bits.size(), 1'b1);
        while (rbsp_bits.size() % 8 != 0) rbsp_bits.insert(rbsp_bits.size(), 1'b0);
        nal_bytes.delete();
        zeros = 0;
        while (rbsp_bits.size() > 0)
        begin
            for (int i = 7; i >= 0; i--) b[i] = rbsp_bits.pop_front();
            if (escape && zeros >= 2 && b <= 8'h03)
            begin
                nal_bytes.insert(nal_bytes.size(), 8'h03);
                zeros = 0;
            end
            nal_bytes.insert(nal_bytes.size(), b);
            zeros = (b == 8'h00) ? zeros + 1 : 0;
        end
    endtask

    task automatic build_sps(int profile, bit full_vui, bit zero_tick);
        int          prof;
        int          chroma;
        int          poc;
        int          cycles;
        logic [7:0]  idc;
        logic [4:0]  fmt;
        bit          flag;
        bit [31:0]   tick;
        int          profiles[6] = '{66, 77, 100, 110, 122, 144};
        rbsp_bits.delete();
        put_bits({1'b0, 2'($urandom), 5'd7}, 8);
        prof = (profile >= 0) ? profile
             : (($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : profiles[$urandom_range(0, 5)]);
        put_bits(prof, 8);
        put_bits($urandom, 16);
        put_ue(pick_code());
        if (prof == 100 || prof == 110 || prof == 122 || prof == 144)
        begin
            chroma = $urandom_range(0, 3);
            put_ue(chroma);
            if (chroma == 3) put_bits($urandom, 1);
            put_ue(pick_code());
            put_ue(pick_code());
            put_bits($urandom, 1);
            flag = ($urandom_range(0, 3) == 0);
            put_bits(flag, 1);
            if (flag)
                for (int i = 0; i < 8; i++) put_bits($urandom_range(0, 15) == 0, 1);
        end
        put_ue(pick_code());
        poc = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 300) : $urandom_range(0, 1);
        put_ue(poc);
        if (poc == 0)
        begin
            put_ue(pick_code());
        end
        else if (poc == 1)
        begin
            put_bits($urandom, 1);
            put_ue(pick_code());
            put_ue(pick_code());
            cycles = $urandom_range(0, 4);
            put_ue(cycles);
            repeat (cycles) put_ue(pick_code());
        end
        put_ue(pick_code());
        put_bits($urandom, 1);
        put_ue(pick_size());
        put_ue(pick_size());
        flag = $urandom_range(0, 1);
        put_bits(flag, 1);
        if (!flag) put_bits($urandom, 1);
        put_bits($urandom, 1);
        flag = $urandom_range(0, 1);
        put_bits(flag, 1);
        if (flag) repeat (4) put_ue(pick_code());
        flag = full_vui || ($urandom_range(0, 3) != 0);
        put_bits(flag, 1);
        if (flag)
        begin
            flag = full_vui || $urandom_range(0, 1);
            put_bits(flag, 1);
            if (flag)
            begin
                idc = (full_vui || $urandom_range(0, 1)) ? 8'd255 : 8'($urandom);
                put_bits(idc, 8);
                if (idc == 8'd255) put_bits($urandom, 32);
            end
            flag = full_vui || $urandom_range(0, 1);
            put_bits(flag, 1);
            if (flag) put_bits($urandom, 1);
            flag = full_vui || $urandom_range(0, 1);
            put_bits(flag, 1);
            if (flag)
            begin
                fmt = $urandom;
                if (full_vui) fmt[0] = 1'b1;
                put_bits(fmt, 5);
                if (fmt[0]) put_bits($urandom, 24);
            end
            flag = full_vui || $urandom_range(0, 1);
            put_bits(flag, 1);
            if (flag) repeat (2) put_ue(pick_code());
            flag = full_vui || zero_tick || ($urandom_range(0, 3) != 0);
            put_bits(flag, 1);
            if (flag)
            begin
                tick = zero_tick ? 32'd0
                     : (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000));
                put_bits(tick, 32);
                put_bits(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000), 32);
                put_bits($urandom, 1);
            end
        end
        repeat ($urandom_range(0, 12))
            rbsp_bits.insert(rbsp_bits.size(), 1'($urandom_range(0, 1)));
    endtask

    task automatic set_pace(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_not_sps();
        nal_bytes = '{8'h09, 8'hF0};
        send_nal();
        nal_bytes = '{8'hFF};
        send_nal();
        nal_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_nal();
    endtask

    task automatic test_emulation();
        nal_bytes = '{8'h65, 8'h00, 8'h00, 8'h03};
        send_nal();
        nal_bytes = '{8'h67, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h03};
        send_nal();
    endtask

    task automatic test_profiles();
        build_sps(66, 1'b1, 1'b0);
        pack_nal(1'b1);
        send_nal();
        build_sps(100, 1'b1, 1'b0);
        pack_nal(1'b1);
        send_nal();
        build_sps(144, 1'b0, 1'b1);
        pack_nal(1'b1);
        send_nal();
    endtask

    task automatic test_long_code();
        rbsp_bits.delete();
        put_bits(8'h67, 8);
        put_bits(66, 8);
        put_bits(16'h0A1E, 16);
        put_bits('0, 40);
        pack_nal(1'b0);
        send_nal();
    endtask

    task automatic test_scaling_and_truncation();
        rbsp_bits.delete();
        put_bits(8'h67, 8);
        put_bits(100, 8);
        put_bits(16'h0028, 16);
        put_ue(0);
        put_ue(3);
        put_bits(1, 1);
        put_ue(0);
        put_ue(0);
        put_bits(0, 1);
        put_bits(1, 1);
        put_bits(8'h01, 8);
        pack_nal(1'b1);
        send_nal();
        build_sps(77, 1'b1, 1'b0);
        pack_nal(1'b1);
        void'(nal_bytes.pop_back());
        void'(nal_bytes.pop_back());
        send_nal();
    endtask

    task automatic test_random_units(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            case ((n / 10) % 4)
                0: set_pace(0, 0);
                1: set_pace(69, 0);
                2: set_pace(0, 69);
                default: set_pace(7, 7);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                nal_bytes.delete();
                repeat ($urandom_range(1, 12)) nal_bytes.insert(nal_bytes.size(), 8'($urandom));
                if ($urandom_range(0, 1)) nal_bytes[0][4:0] = 5'd7;
            end
            else
            begin
                build_sps(-1, $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
                pack_nal($urandom_range(0, 15) != 0);
                if (pick < 20)
                    repeat ($urandom_range(1, nal_bytes.size() - 1)) void'(nal_bytes.pop_back());
            end
            send_nal();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        error_count    = 0;
        quiet_cycles   = 0;
        set_pace(0, 0);
        clear_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_not_sps();
        test_emulation();
        test_profiles();
        test_long_code();
        set_pace(7, 7);
        test_scaling_and_truncation();
        test_random_units(50);
        s_axis_tvalid <= 1'b0;
        while (summary_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
        begin
            $display("h264_sps_header_parser regression: pass");
        end
        else
        begin
            $display("h264_sps_header_parser regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
